/* rtl/prcm_pkg.sv */
// shared widths, register indexes and reset values of the pump runtime meter
`timescale 1ns / 1ps
`default_nettype none
package prcm_pkg;

  // field widths
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned START_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_THRESHOLD = 1'b0,
    CFG_CONSUMPTION     = 1'b1
  } cfg_idx_t;

  // configuration reset values
  localparam logic [CFG_W-1:0] THRESHOLD_RST   = 16'd0;
  localparam logic [CFG_W-1:0] CONSUMPTION_RST = 16'd55;

endpackage
`default_nettype wire

/* rtl/prcm_if.sv */
// beat channels of the pump runtime meter: tick input and result output
`timescale 1ns / 1ps
`default_nettype none
interface prcm_in_if;
  logic                           valid;
  logic                           ready;
  logic [prcm_pkg::PULSE_W-1:0]   pulse_count;
  logic                           at_midnight;
  logic                           clear_request;
  logic                           suspend;
  logic [prcm_pkg::TIME_W-1:0]    now_ms;

  modport source (
    output valid, pulse_count, at_midnight, clear_request, suspend, now_ms,
    input  ready
  );
  modport sink (
    input  valid, pulse_count, at_midnight, clear_request, suspend, now_ms,
    output ready
  );
endinterface

interface prcm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           pump_on;
  logic                           pump_changed;
  logic [prcm_pkg::TIME_W-1:0]    work_time_total;
  logic [prcm_pkg::TIME_W-1:0]    work_time_day;
  logic [prcm_pkg::TIME_W-1:0]    work_time_prev;
  logic [prcm_pkg::TIME_W-1:0]    consumption_total;
  logic [prcm_pkg::TIME_W-1:0]    consumption_day;
  logic [prcm_pkg::TIME_W-1:0]    consumption_prev;
  logic [prcm_pkg::START_W-1:0]   start_count;
  logic [prcm_pkg::TIME_W-1:0]    last_run_ms;
  logic [prcm_pkg::TIME_W-1:0]    current_run_ms;
  logic [prcm_pkg::TIME_W-1:0]    current_consumption;

  modport source (
    output valid, pump_on, pump_changed, work_time_total, work_time_day,
           work_time_prev, consumption_total, consumption_day, consumption_prev,
           start_count, last_run_ms, current_run_ms, current_consumption,
    input  ready
  );
  modport sink (
    input  valid, pump_on, pump_changed, work_time_total, work_time_day,
           work_time_prev, consumption_total, consumption_day, consumption_prev,
           start_count, last_run_ms, current_run_ms, current_consumption,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/pump_runtime_consumption_meter.sv */
// pump runtime and fuel consumption meter top level
// an accepted tick beat passes the tick register, then the state/result register
// throughput: one tick per cycle while out_ch is not stalled; the tick register
// feeds the state registers, which form the result register: one update per cycle
// reset: synchronous active-low rst_n clears all counters, run state and both stages,
// threshold resets to 0 and consumption per second to 55
`timescale 1ns / 1ps
`default_nettype none
module pump_runtime_consumption_meter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  prcm_in_if.sink                                in_ch,
  prcm_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [prcm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [prcm_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned TW = prcm_pkg::TIME_W;
  localparam int unsigned SW = prcm_pkg::START_W;

  // configuration
  logic [prcm_pkg::CFG_W-1:0] threshold_r;
  logic [prcm_pkg::CFG_W-1:0] cps_r;

  // tick register
  logic                         in_vld_r;
  logic [prcm_pkg::PULSE_W-1:0] pulse_r;
  logic                         midnight_r;
  logic                         clear_r;
  logic                         suspend_r;
  logic [TW-1:0]                now_r;

  // state and result register
  logic          out_vld_r;
  logic          changed_r, changed_nxt;
  logic          running_r, running_nxt;
  logic [TW-1:0] sec_total_r, sec_total_nxt;
  logic [TW-1:0] sec_today_r, sec_today_nxt;
  logic [TW-1:0] sec_prev_r, sec_prev_nxt;
  logic [TW-1:0] fuel_total_r, fuel_total_nxt;
  logic [TW-1:0] fuel_today_r, fuel_today_nxt;
  logic [TW-1:0] fuel_prev_r, fuel_prev_nxt;
  logic [SW-1:0] starts_r, starts_nxt;
  logic [TW-1:0] run_start_r, run_start_nxt;
  logic [TW-1:0] run_len_r, run_len_nxt;
  logic [TW-1:0] last_run_r, last_run_nxt;
  logic [TW-1:0] run_fuel_r, run_fuel_nxt;

  logic          advance;
  logic          pump_on;
  logic [TW-1:0] cps_ext;

  // handshake: tick register moves on when the result slot is free or being taken
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign cps_ext      = {{(TW - prcm_pkg::CFG_W){1'b0}}, cps_r};
  assign pump_on      = (pulse_r > threshold_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= prcm_pkg::THRESHOLD_RST;
      cps_r       <= prcm_pkg::CONSUMPTION_RST;
    end else if (cfg_we) begin
      case (prcm_pkg::cfg_idx_t'(cfg_idx))
        prcm_pkg::CFG_PULSE_THRESHOLD: threshold_r <= cfg_wdata;
        prcm_pkg::CFG_CONSUMPTION:     cps_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pulse_r    <= in_ch.pulse_count;
      midnight_r <= in_ch.at_midnight;
      clear_r    <= in_ch.clear_request;
      suspend_r  <= in_ch.suspend;
      now_r      <= in_ch.now_ms;
    end
  end

  // per-tick update, skipped while suspended: rollover, edge handling, accumulation, clear
  always_comb begin
    changed_nxt    = 1'b0;
    running_nxt    = running_r;
    sec_total_nxt  = sec_total_r;
    sec_today_nxt  = sec_today_r;
    sec_prev_nxt   = sec_prev_r;
    fuel_total_nxt = fuel_total_r;
    fuel_today_nxt = fuel_today_r;
    fuel_prev_nxt  = fuel_prev_r;
    starts_nxt     = starts_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    last_run_nxt   = last_run_r;
    run_fuel_nxt   = run_fuel_r;

    if (!suspend_r) begin
      // midnight rollover
      if (midnight_r) begin
        sec_prev_nxt   = sec_today_r;
        sec_today_nxt  = '0;
        fuel_prev_nxt  = fuel_today_r;
        fuel_today_nxt = '0;
        starts_nxt     = '0;
      end

      // on/off edges
      running_nxt = pump_on;
      if (pump_on != running_r) begin
        changed_nxt  = 1'b1;
        run_fuel_nxt = '0;
        if (pump_on) begin
          starts_nxt    = starts_nxt + SW'(1);
          run_start_nxt = now_r;
        end else begin
          last_run_nxt = run_len_r;
          run_len_nxt  = '0;
        end
      end

      // accumulation while running
      if (pump_on) begin
        sec_total_nxt  = sec_total_nxt + TW'(1);
        sec_today_nxt  = sec_today_nxt + TW'(1);
        fuel_total_nxt = fuel_total_nxt + cps_ext;
        fuel_today_nxt = fuel_today_nxt + cps_ext;
        run_fuel_nxt   = run_fuel_nxt + cps_ext;
        run_len_nxt    = now_r - run_start_nxt;
      end

      // clear request
      if (clear_r) begin
        sec_total_nxt  = '0;
        sec_today_nxt  = '0;
        sec_prev_nxt   = '0;
        fuel_total_nxt = '0;
        fuel_today_nxt = '0;
        fuel_prev_nxt  = '0;
        starts_nxt     = '0;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // state / result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r    <= 1'b0;
      running_r    <= 1'b0;
      sec_total_r  <= '0;
      sec_today_r  <= '0;
      sec_prev_r   <= '0;
      fuel_total_r <= '0;
      fuel_today_r <= '0;
      fuel_prev_r  <= '0;
      starts_r     <= '0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      last_run_r   <= '0;
      run_fuel_r   <= '0;
    end else if (advance) begin
      changed_r    <= changed_nxt;
      running_r    <= running_nxt;
      sec_total_r  <= sec_total_nxt;
      sec_today_r  <= sec_today_nxt;
      sec_prev_r   <= sec_prev_nxt;
      fuel_total_r <= fuel_total_nxt;
      fuel_today_r <= fuel_today_nxt;
      fuel_prev_r  <= fuel_prev_nxt;
      starts_r     <= starts_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      last_run_r   <= last_run_nxt;
      run_fuel_r   <= run_fuel_nxt;
    end
  end

  // result beat
  assign out_ch.valid               = out_vld_r;
  assign out_ch.pump_on             = running_r;
  assign out_ch.pump_changed        = changed_r;
  assign out_ch.work_time_total     = sec_total_r;
  assign out_ch.work_time_day       = sec_today_r;
  assign out_ch.work_time_prev      = sec_prev_r;
  assign out_ch.consumption_total   = fuel_total_r;
  assign out_ch.consumption_day     = fuel_today_r;
  assign out_ch.consumption_prev    = fuel_prev_r;
  assign out_ch.start_count         = starts_r;
  assign out_ch.last_run_ms         = last_run_r;
  assign out_ch.current_run_ms      = run_len_r;
  assign out_ch.current_consumption = run_fuel_r;

  // no run length or run fuel while the pump is off
  a_off_no_run : assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (run_len_r == '0) && (run_fuel_r == '0))
    else $error("run length or fuel nonzero while pump off");

  // a pending switch-on result shows a fresh run
  a_on_fresh : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && changed_r && running_r |-> (run_len_r == '0) && (run_fuel_r == cps_ext))
    else $error("switch-on result does not start a fresh run");

  // a stalled result keeps the state frozen
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> $stable(sec_total_r) && $stable(running_r)
                                   && $stable(fuel_total_r) && out_vld_r)
    else $error("state moved while result stalled");

  // a waiting tick is neither lost nor overwritten
  a_tick_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(now_r) && $stable(pulse_r))
    else $error("waiting tick lost");

  // a suspended tick leaves the accumulators untouched
  a_suspend : assert property (@(posedge clk) disable iff (!rst_n)
    advance && suspend_r |=> !changed_r && $stable(fuel_total_r) && $stable(starts_r))
    else $error("suspended tick changed state");

endmodule
`default_nettype wire
